[hw/rtl/pmfs_pkg.sv]
// Shared types, constants and lookups for the payment message field splitter.
package pmfs_pkg;

	localparam logic [5:0] TypeLength   = 6'd4;
	localparam logic [5:0] BitmapLength = 6'd12;
	localparam logic [5:0] NumElements  = 6'd12;
	localparam logic [7:0] PresentMark  = 8'h31;

	// Section codes as seen on the result channel.
	localparam logic [1:0] SEC_TYPE   = 2'd0;
	localparam logic [1:0] SEC_BITMAP = 2'd1;
	localparam logic [1:0] SEC_DATA   = 2'd2;
	localparam logic [1:0] SEC_TRAIL  = 2'd3;

	typedef struct packed {
		logic [1:0] section;
		logic [3:0] element_number;
		logic [7:0] char_out;
		logic [4:0] offset_in_field;
		logic       end_of_field;
		logic       truncated;
	} result_t;

	// Fixed length of data element 1..12.
	function automatic logic [4:0] elem_len(input logic [3:0] el);
		logic [4:0] len;
		unique case (el)
			4'd1:    len = 5'd8;
			4'd2:    len = 5'd19;
			4'd3:    len = 5'd6;
			4'd4:    len = 5'd16;
			4'd5:    len = 5'd16;
			4'd6:    len = 5'd16;
			4'd7:    len = 5'd10;
			4'd8:    len = 5'd12;
			4'd9:    len = 5'd8;
			4'd10:   len = 5'd8;
			4'd11:   len = 5'd12;
			4'd12:   len = 5'd14;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Lowest present element with a number above 'after'; zero when none.
	function automatic logic [3:0] next_present(input logic [11:0] bits,
		input logic [3:0] after);
		logic [3:0] nxt;
		nxt = 4'd0;
		for (int k = 11; k >= 0; k--) begin
			if (bits[k] && (4'(k) >= after)) begin
				nxt = 4'(k + 1);
			end
		end
		return nxt;
	endfunction

endpackage

[hw/rtl/payment_message_field_splitter_core.sv]
// Top level of the payment message field splitter: tags each message character.
//
// Usage:
//   Characters enter on the char channel (char_in, last_char, char_valid,
//   char_stall), one per transaction. Every input transaction yields exactly
//   one result transaction on the result channel (section, element_number,
//   char_out, offset_in_field, end_of_field, truncated, result_valid,
//   result_stall).
//   The parser walks through the message type (4 characters), the presence
//   bitmap (12 characters, '1' marks an element present), the present data
//   elements at their fixed lengths, and then trailing characters.
//   A character with last_char set ends the message; truncated reports a
//   message that stopped inside a required field, and the parser returns to
//   the message type phase for the next character.
//   A result is registered in the result register, or in the skid register
//   when the result register is held. Throughput: one character per cycle
//   while char_stall is low, set by the combinational tagging logic between
//   the parser state registers and the output stage. Stalls: a two-entry
//   output stage (result register plus skid register) absorbs one extra
//   transaction; char_stall rises only when the skid register is occupied, so char_stall is a registered signal.
//   Reset (arst_n low): parser state returns to the message type phase, the
//   presence bitmap clears and both output entries are emptied.
module payment_message_field_splitter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_in,
	input  logic       last_char,
	input  logic       char_valid,
	output logic       char_stall,
	output logic [1:0] section,
	output logic [3:0] element_number,
	output logic [7:0] char_out,
	output logic [4:0] offset_in_field,
	output logic       end_of_field,
	output logic       truncated,
	output logic       result_valid,
	input  logic       result_stall
);

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_BITMAP,
		PH_DATA,
		PH_TRAIL
	} phase_t;

	// Parser state
	phase_t      phase_q;
	logic [4:0]  pos_q;
	logic [11:0] pres_q;
	logic [3:0]  elem_q;

	// Next-state values and the result for the character on the input
	phase_t      phase_d;
	logic [4:0]  pos_d;
	logic [11:0] pres_d;
	logic [3:0]  elem_d;
	pmfs_pkg::result_t res_d;

	// Output stage
	pmfs_pkg::result_t out_q;
	pmfs_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;

	logic accept;
	logic drain;

	assign char_stall = skid_valid_q;
	assign accept     = char_valid && !skid_valid_q;
	assign drain      = out_valid_q && !result_stall;

	// Tag the incoming character and work out the parser's next state.
	always_comb begin
		logic [5:0]  pos_inc;
		logic [11:0] pres_set;
		logic [3:0]  nxt;
		pos_inc  = {1'b0, pos_q} + 6'd1;
		pres_set = pres_q;
		nxt      = 4'd0;

		phase_d = phase_q;
		pos_d   = pos_q;
		pres_d  = pres_q;
		elem_d  = elem_q;

		res_d.section         = pmfs_pkg::SEC_TRAIL;
		res_d.element_number  = 4'd0;
		res_d.char_out        = char_in;
		res_d.offset_in_field = 5'd0;
		res_d.end_of_field    = 1'b0;
		res_d.truncated       = 1'b0;

		unique case (phase_q)
			PH_TYPE: begin
				res_d.section         = pmfs_pkg::SEC_TYPE;
				res_d.offset_in_field = pos_q;
				if (pos_inc >= pmfs_pkg::TypeLength) begin
					res_d.end_of_field = 1'b1;
					phase_d            = PH_BITMAP;
					pos_d              = 5'd0;
				end else begin
					pos_d = pos_inc[4:0];
				end
			end
			PH_BITMAP: begin
				res_d.section         = pmfs_pkg::SEC_BITMAP;
				res_d.offset_in_field = pos_q;
				// Only the first twelve bitmap characters count as marks.
				if (({1'b0, pos_q} < pmfs_pkg::NumElements)
					&& (char_in == pmfs_pkg::PresentMark)) begin
					pres_set = pres_q | (12'd1 << pos_q[3:0]);
				end
				pres_d = pres_set;
				if (pos_inc >= pmfs_pkg::BitmapLength) begin
					res_d.end_of_field = 1'b1;
					nxt                = pmfs_pkg::next_present(pres_set, 4'd0);
					pos_d              = 5'd0;
					elem_d             = nxt;
					phase_d            = (nxt != 4'd0) ? PH_DATA : PH_TRAIL;
				end else begin
					pos_d = pos_inc[4:0];
				end
			end
			PH_DATA: begin
				if ((elem_q >= 4'd1) && ({2'b00, elem_q} <= pmfs_pkg::NumElements)) begin
					res_d.section         = pmfs_pkg::SEC_DATA;
					res_d.element_number  = elem_q;
					res_d.offset_in_field = pos_q;
					if (pos_inc >= {1'b0, pmfs_pkg::elem_len(elem_q)}) begin
						res_d.end_of_field = 1'b1;
						nxt                = pmfs_pkg::next_present(pres_q, elem_q);
						pos_d              = 5'd0;
						elem_d             = nxt;
						phase_d            = (nxt != 4'd0) ? PH_DATA : PH_TRAIL;
					end else begin
						pos_d = pos_inc[4:0];
					end
				end else begin
					// Out-of-range element number: fall into the trailing part.
					phase_d = PH_TRAIL;
					pos_d   = 5'd0;
					elem_d  = 4'd0;
				end
			end
			PH_TRAIL: begin
				// Trailing characters leave the state alone.
			end
			default: begin
				phase_d = PH_TRAIL;
			end
		endcase

		// End of message: flag an unfinished field and drop back to reset state.
		if (last_char) begin
			res_d.truncated = (phase_d != PH_TRAIL);
			phase_d         = PH_TYPE;
			pos_d           = 5'd0;
			pres_d          = 12'd0;
			elem_d          = 4'd0;
		end
	end

	// Parser state and output entry valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TYPE;
			pos_q        <= 5'd0;
			pres_q       <= 12'd0;
			elem_q       <= 4'd0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				pres_q  <= pres_d;
				elem_q  <= elem_d;
			end
			if (skid_valid_q) begin
				// Move the held transaction forward once the receiver takes one.
				if (drain) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (out_valid_q && !drain) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (drain) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: no reset needed.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !drain) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign result_valid    = out_valid_q;
	assign section         = out_q.section;
	assign element_number  = out_q.element_number;
	assign char_out        = out_q.char_out;
	assign offset_in_field = out_q.offset_in_field;
	assign end_of_field    = out_q.end_of_field;
	assign truncated       = out_q.truncated;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the payment message field splitter core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Directed rows: a row with 'typed' set carries its expected tag, others are predicted.
	typedef struct packed {
		logic [7:0]        ch;
		logic              last;
		logic              typed;
		pmfs_pkg::result_t tag;
	} stim_row_t;

	localparam int NumDirected   = 24;
	localparam int RandomChars   = 1900;
	localparam int WatchdogLimit = 3000;
	localparam int HoldOffCycles = 80;
	localparam int IdlePercent   = 37;

	// Fixed length of data elements 1..12, indexed from zero.
	localparam logic [4:0] FieldLength [12] = '{
		5'd8, 5'd19, 5'd6, 5'd16, 5'd16, 5'd16, 5'd10, 5'd12, 5'd8, 5'd8, 5'd12, 5'd14
	};

	// Chance, in percent, that a bitmap position is marked present.
	localparam int MarkOdds [4] = '{0, 20, 50, 100};

	localparam stim_row_t DirectedRows [NumDirected] = '{
		// lone characters that end a message inside its type field
		'{8'h00, 1'b1, 1'b1, '{pmfs_pkg::SEC_TYPE, 4'd0, 8'h00, 5'd0, 1'b0, 1'b1}},
		'{8'hFF, 1'b1, 1'b1, '{pmfs_pkg::SEC_TYPE, 4'd0, 8'hFF, 5'd0, 1'b0, 1'b1}},
		// complete message with an empty bitmap and two trailing characters
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h32, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b1, '{pmfs_pkg::SEC_TYPE, 4'd0, 8'h30, 5'd3, 1'b1, 1'b0}},
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h32, 1'b0, 1'b0, '0},
		'{8'hB1, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h7F, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h20, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b1, '{pmfs_pkg::SEC_BITMAP, 4'd0, 8'h30, 5'd11, 1'b1, 1'b0}},
		'{8'h58, 1'b0, 1'b1, '{pmfs_pkg::SEC_TRAIL, 4'd0, 8'h58, 5'd0, 1'b0, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, '{pmfs_pkg::SEC_TRAIL, 4'd0, 8'hFF, 5'd0, 1'b0, 1'b0}},
		// message that stops right after its type, bitmap still owed
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h31, 1'b0, 1'b0, '0},
		'{8'h30, 1'b0, 1'b0, '0},
		'{8'h30, 1'b1, 1'b1, '{pmfs_pkg::SEC_TYPE, 4'd0, 8'h30, 5'd3, 1'b1, 1'b1}}
	};

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic [7:0] char_in        = 8'h00;
	logic       last_char      = 1'b0;
	logic       char_valid     = 1'b0;
	logic       result_stall   = 1'b0;
	logic       char_stall;
	logic [1:0] section;
	logic [3:0] element_number;
	logic [7:0] char_out;
	logic [4:0] offset_in_field;
	logic       end_of_field;
	logic       truncated;
	logic       result_valid;

	// Parser state as the predictor sees it.
	logic [1:0]  msg_phase      = pmfs_pkg::SEC_TYPE;
	logic [4:0]  field_pos      = 5'd0;
	logic [11:0] present_map    = 12'd0;
	logic [3:0]  active_element = 4'd0;

	pmfs_pkg::result_t expected_tags[$];
	int      mismatch_count = 0;
	int      chars_sent     = 0;
	int      idle_cycles    = 0;
	bit      quiet          = 1'b0;
	bit      hold_request   = 1'b0;

	payment_message_field_splitter_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_in         (char_in),
		.last_char       (last_char),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.section         (section),
		.element_number  (element_number),
		.char_out        (char_out),
		.offset_in_field (offset_in_field),
		.end_of_field    (end_of_field),
		.truncated       (truncated),
		.result_valid    (result_valid),
		.result_stall    (result_stall)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
		end
	endtask

	// Step past the element just finished: move to the next present one, or to trailing.
	task automatic move_to_next_element(input logic [3:0] after);
		logic [3:0] nxt;
		nxt = 4'd0;
		for (int k = 0; k < 12; k++) begin
			if (nxt == 4'd0 && k >= int'(after) && present_map[k]) begin
				nxt = 4'(k + 1);
			end
		end
		field_pos      = 5'd0;
		active_element = nxt;
		msg_phase      = (nxt != 4'd0) ? pmfs_pkg::SEC_DATA : pmfs_pkg::SEC_TRAIL;
	endtask

	// Work out the tag of one accepted character and advance the parser state.
	task automatic tag_character(input logic [7:0] c, input logic last,
		output pmfs_pkg::result_t tag);
		tag          = '0;
		tag.char_out = c;
		tag.section  = pmfs_pkg::SEC_TRAIL;
		case (msg_phase)
			pmfs_pkg::SEC_TYPE: begin
				tag.section         = pmfs_pkg::SEC_TYPE;
				tag.offset_in_field = field_pos;
				if ({1'b0, field_pos} + 6'd1 >= pmfs_pkg::TypeLength) begin
					tag.end_of_field = 1'b1;
					msg_phase        = pmfs_pkg::SEC_BITMAP;
					field_pos        = 5'd0;
				end else begin
					field_pos = field_pos + 5'd1;
				end
			end
			pmfs_pkg::SEC_BITMAP: begin
				tag.section         = pmfs_pkg::SEC_BITMAP;
				tag.offset_in_field = field_pos;
				// only the first twelve bitmap positions carry presence marks
				if ({1'b0, field_pos} < pmfs_pkg::NumElements
					&& c == pmfs_pkg::PresentMark) begin
					present_map[field_pos[3:0]] = 1'b1;
				end
				if ({1'b0, field_pos} + 6'd1 >= pmfs_pkg::BitmapLength) begin
					tag.end_of_field = 1'b1;
					move_to_next_element(4'd0);
				end else begin
					field_pos = field_pos + 5'd1;
				end
			end
			pmfs_pkg::SEC_DATA: begin
				if (active_element >= 4'd1 && active_element <= 4'd12) begin
					tag.section         = pmfs_pkg::SEC_DATA;
					tag.element_number  = active_element;
					tag.offset_in_field = field_pos;
					if ({1'b0, field_pos} + 6'd1 >=
						{1'b0, FieldLength[active_element - 4'd1]}) begin
						tag.end_of_field = 1'b1;
						move_to_next_element(active_element);
					end else begin
						field_pos = field_pos + 5'd1;
					end
				end else begin
					msg_phase      = pmfs_pkg::SEC_TRAIL;
					field_pos      = 5'd0;
					active_element = 4'd0;
				end
			end
			default: begin
			end
		endcase
		// The last character closes the message: flag an owed field, then clear the parser.
		if (last) begin
			tag.truncated  = (msg_phase != pmfs_pkg::SEC_TRAIL);
			msg_phase      = pmfs_pkg::SEC_TYPE;
			field_pos      = 5'd0;
			present_map    = 12'd0;
			active_element = 4'd0;
		end
	endtask

	// Offer one character, hold it until the core takes it, then queue its expected tag.
	// Entered and left just after a rising edge, with no assignment yet made in that step.
	task automatic send_char(input logic [7:0] c, input logic last, input logic typed,
		input pmfs_pkg::result_t typed_tag);
		pmfs_pkg::result_t tag;
		while (!quiet && $urandom_range(99) < IdlePercent) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_in    <= c;
		last_char  <= last;
		char_valid <= 1'b1;
		@(posedge clk);
		while (char_stall) begin
			@(posedge clk);
		end
		tag_character(c, last, tag);
		expected_tags.push_back(typed ? typed_tag : tag);
		chars_sent++;
	endtask

	// Receiver: stall at random, drop stalls in quiet stretches, and hold off once for a
	// long stretch so the output stage fills and the core stalls its input.
	initial begin
		bit hold_served;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				result_stall <= 1'b1;
				repeat (HoldOffCycles) @(posedge clk);
			end else begin
				result_stall <= !quiet && ($urandom_range(99) < IdlePercent);
			end
		end
	end

	// Check every result transaction against the oldest expected tag, field by field.
	always @(posedge clk) begin : watch_results
		pmfs_pkg::result_t seen;
		pmfs_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			seen = '{section, element_number, char_out, offset_in_field, end_of_field,
				truncated};
			if (expected_tags.size() == 0) begin
				report_mismatch($sformatf("result %0h with nothing expected", seen));
			end else begin
				want = expected_tags.pop_front();
				check_field("section", 8'(seen.section), 8'(want.section));
				check_field("element_number", 8'(seen.element_number),
					8'(want.element_number));
				check_field("char_out", seen.char_out, want.char_out);
				check_field("offset_in_field", 8'(seen.offset_in_field),
					8'(want.offset_in_field));
				check_field("end_of_field", 8'(seen.end_of_field), 8'(want.end_of_field));
				check_field("truncated", 8'(seen.truncated), 8'(want.truncated));
			end
		end
	end

	// Watchdog: end the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WatchdogLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [8:0]  message_chars[$];
		logic [11:0] marks;
		logic [7:0]  ch;
		int          kind;
		int          odds;
		int          cut;
		bit          hold_asked;
		hold_asked = 1'b0;

		// Hold reset, then release it on a rising edge.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows first: extremes of the character, truncation inside and just
		// after the type field, an empty bitmap leading straight into trailing characters.
		for (int r = 0; r < NumDirected; r++) begin
			send_char(DirectedRows[r].ch, DirectedRows[r].last, DirectedRows[r].typed,
				DirectedRows[r].tag);
		end

		// Random messages: mostly well-formed with random content, some cut short,
		// some plain noise with scattered last flags.
		while (chars_sent < NumDirected + RandomChars) begin
			// Once, pause the sender until the core has drained, then ask for the long
			// hold-off on the result side while the next message is offered.
			if (!hold_asked && chars_sent >= 700) begin
				hold_asked = 1'b1;
				char_valid <= 1'b0;
				do begin
					@(posedge clk);
				end while (expected_tags.size() != 0);
				hold_request = 1'b1;
			end
			// a stretch with no idling on either side
			quiet = (chars_sent >= 1100 && chars_sent < 1400);

			message_chars.delete();
			kind = $urandom_range(9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 40)) begin
					message_chars.push_back({($urandom_range(15) == 0), 8'($urandom)});
				end
			end else begin
				odds  = MarkOdds[$urandom_range(3)];
				marks = 12'd0;
				repeat (4) message_chars.push_back({1'b0, 8'($urandom)});
				for (int k = 0; k < 12; k++) begin
					if ($urandom_range(99) < odds) begin
						marks[k] = 1'b1;
						message_chars.push_back({1'b0, pmfs_pkg::PresentMark});
					end else begin
						ch = 8'($urandom);
						if (ch == pmfs_pkg::PresentMark) begin
							ch = 8'h30;
						end
						message_chars.push_back({1'b0, ch});
					end
				end
				for (int e = 0; e < 12; e++) begin
					if (marks[e]) begin
						repeat (int'(FieldLength[e])) message_chars.push_back({1'b0, 8'($urandom)});
					end
				end
				repeat ($urandom_range(0, 3)) message_chars.push_back({1'b0, 8'($urandom)});
				// cut some messages short, anywhere up to their full length
				if (kind <= 2) begin
					cut = $urandom_range(1, message_chars.size());
					while (message_chars.size() > cut) begin
						void'(message_chars.pop_back());
					end
				end
			end
			message_chars[message_chars.size() - 1][8] = 1'b1;

			foreach (message_chars[i]) begin
				send_char(message_chars[i][7:0], message_chars[i][8], 1'b0, '0);
			end
		end

		// Drop valid, wait for every expected tag, then wait on for strays before the verdict.
		char_valid <= 1'b0;
		while (expected_tags.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
